// ===== src/lcdcb_pkg.sv =====
// lcdcb_pkg: screen geometry, register and mode codes, palette tables
// and the per-pixel color conversion for the lcd color convert / blend block
// depends on nothing
`default_nettype none

package lcdcb_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int PIX_W  = 15;
  localparam int WORD_W = 32;

  // configuration register indexes
  localparam logic [1:0] REG_SYSTEM_MODE     = 2'd0;
  localparam logic [1:0] REG_COLOR_EMULATION = 2'd1;
  localparam logic [1:0] REG_BLUR_EMULATION  = 2'd2;

  // system modes
  localparam logic [1:0] MODE_MONO  = 2'd0;
  localparam logic [1:0] MODE_PASS  = 2'd1;
  localparam logic [1:0] MODE_COLOR = 2'd2;

  localparam logic [9:0] MIX_LIMIT = 10'd960;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  function automatic logic [WORD_W-1:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
    pack_rgb = {ALPHA_OPAQUE, r, g, b};
  endfunction

  // green-tinted monochrome palette, high bytes only
  function automatic logic [WORD_W-1:0] tint_word(input logic [1:0] shade);
    logic [WORD_W-1:0] w;
    case (shade)
      2'd0:    w = pack_rgb(8'hae, 8'hd9, 8'h27);
      2'd1:    w = pack_rgb(8'h58, 8'ha0, 8'h28);
      2'd2:    w = pack_rgb(8'h20, 8'h62, 8'h29);
      2'd3:    w = pack_rgb(8'h1a, 8'h45, 8'h2a);
      default: w = pack_rgb(8'h1a, 8'h45, 8'h2a);
    endcase
    tint_word = w;
  endfunction

  // grey ramp, shade 0 brightest
  function automatic logic [7:0] grey_level(input logic [1:0] shade);
    logic [7:0] l;
    case (shade)
      2'd0:    l = 8'hff;
      2'd1:    l = 8'haa;
      2'd2:    l = 8'h55;
      2'd3:    l = 8'h00;
      default: l = 8'h00;
    endcase
    grey_level = l;
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] clamp_mix(input logic [9:0] v);
    logic [9:0] c;
    c = (v > MIX_LIMIT) ? MIX_LIMIT : v;
    clamp_mix = c[9:2];
  endfunction

  function automatic logic [WORD_W-1:0] convert(input logic [1:0] mode, input logic emu,
                                                input logic [PIX_W-1:0] px);
    logic [4:0] r, g, b;
    logic [9:0] mr, mg, mb;
    logic [7:0] lv;
    logic [WORD_W-1:0] w;
    r  = px[4:0];
    g  = px[9:5];
    b  = px[14:10];
    // products are formed at 10 bits, the largest weighted sum is 992
    mr = 10'(r) * 10'd26 + 10'({g, 2'b00}) + 10'({b, 1'b0});
    mg = 10'(g) * 10'd24 + 10'({b, 3'b000});
    mb = 10'(r) * 10'd6 + 10'({g, 2'b00}) + 10'(b) * 10'd22;
    lv = grey_level(px[1:0]);
    case (mode)
      MODE_MONO:  w = emu ? tint_word(px[1:0]) : pack_rgb(lv, lv, lv);
      MODE_COLOR: w = emu ? pack_rgb(clamp_mix(mr), clamp_mix(mg), clamp_mix(mb))
                          : pack_rgb(widen5(r), widen5(g), widen5(b));
      default:    w = WORD_W'(px);
    endcase
    convert = w;
  endfunction

  // floor average of each byte, no carry between bytes
  function automatic logic [WORD_W-1:0] blend_bytes(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] w;
    logic [8:0] s;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, a[i*8 +: 8]} + {1'b0, b[i*8 +: 8]};
      w[i*8 +: 8] = s[8:1];
    end
    blend_bytes = w;
  endfunction

endpackage

`default_nettype wire

// ===== src/lcdcb_in_if.sv =====
// lcdcb_in_if: input pixel channel, valid/ready with pixel value and address
// depends on lcdcb_pkg
`default_nettype none

interface lcdcb_in_if
  import lcdcb_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic [PIX_W-1:0] pixel_address;

  modport source (output valid, output pixel_value, output pixel_address, input ready);
  modport sink   (input valid, input pixel_value, input pixel_address, output ready);
endinterface

`default_nettype wire

// ===== src/lcdcb_out_if.sv =====
// lcdcb_out_if: result channel, valid/ready with one argb color word
// depends on lcdcb_pkg
`default_nettype none

interface lcdcb_out_if
  import lcdcb_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] color_word;

  modport source (output valid, output color_word, input ready);
  modport sink   (input valid, input color_word, output ready);
endinterface

`default_nettype wire

// ===== src/handheld_lcd_color_convert_blend_top.sv =====
// handheld_lcd_color_convert_blend_top: pixel color conversion with frame-store blend
// depends on lcdcb_pkg, lcdcb_in_if, lcdcb_out_if
//
//   channel   direction  handshake            payload
//   in_pix    sink       valid/ready          pixel_value[14:0], pixel_address[14:0]
//   out_pix   source     valid/ready          color_word[31:0]
//   cfg_*     write      cfg_we               cfg_index[1:0], cfg_wdata[1:0]
//
// one pixel per cycle sustained while out_pix.ready holds; an accepted transaction passes the
// stage-1 registers (frame-store read), then the output register (blend and write-back)
// after reset the frame store is cleared one word a cycle, all STORE_DEPTH words
// (23040 for 160x144); in_pix.ready stays low until that pass is done
// a stall on out_pix holds the output register, then the blend stage, then in_pix
`default_nettype none

module handheld_lcd_color_convert_blend_top
  import lcdcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  lcdcb_in_if.sink        in_pix,
  lcdcb_out_if.source     out_pix,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_wdata
);

  // configuration registers
  logic [1:0] system_mode_r;
  logic       color_emulation_r;
  logic       blur_emulation_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      system_mode_r     <= MODE_MONO;
      color_emulation_r <= 1'b0;
      blur_emulation_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYSTEM_MODE:     system_mode_r     <= cfg_wdata;
        REG_COLOR_EMULATION: color_emulation_r <= cfg_wdata[0];
        REG_BLUR_EMULATION:  blur_emulation_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clearing pass over the frame store after reset
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_pix.ready);
  assign in_pix.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc       = in_pix.valid && in_pix.ready;

  // stage 0: convert and issue the frame-store read
  logic              in_range;
  logic [ADDR_W-1:0] in_index;

  assign in_range = {17'b0, in_pix.pixel_address} < 32'(STORE_DEPTH);
  assign in_index = ADDR_W'(in_pix.pixel_address);

  logic [WORD_W-1:0] s1_fresh_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fresh_r    <= convert(system_mode_r, color_emulation_r, in_pix.pixel_value);
      s1_addr_r     <= in_index;
      s1_in_range_r <= in_range;
    end
  end

  // stage 1: blend with the stored word and write the result back
  // the write of the previous transaction lands on the same edge as this read,
  // so it is forwarded from the last-write register
  logic [WORD_W-1:0] rdata_r;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [WORD_W-1:0] fwd_data_r;
  logic [WORD_W-1:0] prev_word;
  logic [WORD_W-1:0] out_data_nxt;

  always_comb begin
    if (!s1_in_range_r) begin
      prev_word = '0;
    end else if (fwd_valid_r && fwd_addr_r == s1_addr_r) begin
      prev_word = fwd_data_r;
    end else begin
      prev_word = rdata_r;
    end
    out_data_nxt = blur_emulation_r ? blend_bytes(s1_fresh_r, prev_word) : s1_fresh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_adv && s1_in_range_r) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_in_range_r) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= out_data_nxt;
    end
  end

  // frame store: one write port, one registered read port
  logic [WORD_W-1:0] frame_mem [STORE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  assign mem_we    = clearing_r || (s1_adv && s1_in_range_r);
  assign mem_waddr = clearing_r ? clr_cnt_r : s1_addr_r;
  assign mem_wdata = clearing_r ? '0 : out_data_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_r <= frame_mem[in_index];
    end
  end

  // output register
  logic [WORD_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.color_word = out_data_r;

  // checks
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_acc)
    else $error("input transaction accepted during frame-store clear");

  a_blend_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && out_data_r == $past(out_data_nxt))
    else $error("blend result not loaded into output register");

  a_clear_covers_store: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_cnt_r) == ADDR_W'(STORE_DEPTH - 1))
    else $error("frame-store clear ended early");

  a_forward_only_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_in_range_r) |=> fwd_valid_r && fwd_addr_r == $past(s1_addr_r))
    else $error("last-write register not updated on write-back");

endmodule

`default_nettype wire
